// File: hw/rtl/c8x_pkg.sv
//==============================================================================
// c8x_pkg
// Shared types and constants for the CHIP-8 instruction execute block.
//==============================================================================
`default_nettype none
package c8x_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_EXEC  = 2'd2,
      OP_TICK  = 2'd3
   } req_op_type;

   typedef enum logic [1:0] {
      DISP_NONE  = 2'd0,
      DISP_CLEAR = 2'd1,
      DISP_DRAW  = 2'd2
   } disp_cmd_type;

   localparam logic [15:0] W_CLS = 16'h00E0;
   localparam logic [15:0] W_RET = 16'h00EE;
   localparam logic [7:0]  K_SKP  = 8'h9E;
   localparam logic [7:0]  K_SKNP = 8'hA1;
   localparam logic [7:0]  K_GDT  = 8'h07;
   localparam logic [7:0]  K_WKEY = 8'h0A;
   localparam logic [7:0]  K_SDT  = 8'h15;
   localparam logic [7:0]  K_SST  = 8'h18;
   localparam logic [7:0]  K_ADDI = 8'h1E;
   localparam logic [7:0]  K_FONT = 8'h29;
   localparam logic [7:0]  K_BCD  = 8'h33;
   localparam logic [7:0]  K_STR  = 8'h55;
   localparam logic [7:0]  K_LDR  = 8'h65;
   localparam logic [7:0]  SHL_LIMIT = 8'h7F;
   localparam logic [11:0] PC_RESET = 12'd512;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDWAIT,
      ST_FETCH_HI,
      ST_FETCH_LO,
      ST_DECODE,
      ST_EXEC,
      ST_BCD,
      ST_BLK_RD,
      ST_BLK_WAIT,
      ST_BLK_WR,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch request
      logic mem_write;   // host byte write
      logic mem_read;    // host byte read issue
      logic rd_capture;  // latch host read data
      logic fetch_hi;    // issue high fetch read
      logic fetch_lo;    // latch high byte, issue low read
      logic decode;      // latch word
      logic exec;        // perform the execute step
      logic tick;        // timer tick
      logic bcd_wr;      // write one BCD digit
      logic blk_rd;      // issue block load read
      logic blk_ld;      // latch block load byte into register
      logic blk_wr;      // write block store byte
      logic out_load;    // register result
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      req_op_type op;
      logic       is_bcd;
      logic       is_str;
      logic       is_ldr;
      logic       cnt_last;  // block or BCD counter at final step
   } sts_type;

endpackage
`default_nettype wire

// File: hw/rtl/c8x_req_if.sv
//==============================================================================
// c8x_req_if
// Request channel: valid/ready with the instruction item payload.
//==============================================================================
`default_nettype none
interface c8x_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [11:0] address;
   logic [7:0]  write_data;
   logic [15:0] key_mask;
   logic [7:0]  random_byte;
   modport source (output valid, opcode, address, write_data, key_mask, random_byte,
                   input ready);
   modport sink (input valid, opcode, address, write_data, key_mask, random_byte,
                 output ready);
endinterface
`default_nettype wire

// File: hw/rtl/c8x_rsp_if.sv
//==============================================================================
// c8x_rsp_if
// Response channel: valid/ready with the result payload.
//==============================================================================
`default_nettype none
interface c8x_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] program_counter;
   logic [15:0] index_value;
   logic [1:0]  display_command;
   logic [7:0]  draw_x;
   logic [7:0]  draw_y;
   logic [3:0]  draw_rows;
   logic [7:0]  read_data;
   logic        halted;
   logic        waiting_key;
   logic        sound_on;
   modport source (output valid, program_counter, index_value, display_command, draw_x,
                   draw_y, draw_rows, read_data, halted, waiting_key, sound_on,
                   input ready);
   modport sink (input valid, program_counter, index_value, display_command, draw_x,
                 draw_y, draw_rows, read_data, halted, waiting_key, sound_on,
                 output ready);
endinterface
`default_nettype wire

// File: hw/rtl/c8x_ram.sv
//==============================================================================
// c8x_ram
// Generic single-port RAM with registered read.
//==============================================================================
`default_nettype none
module c8x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// File: hw/rtl/c8x_ctrl.sv
//==============================================================================
// c8x_ctrl
// Sequencer: steps each transaction through host access, timer tick, fetch, execute and memory walks.
//==============================================================================
`default_nettype none
module c8x_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire c8x_pkg::sts_type sts,
   output c8x_pkg::ctl_type      ctl
);
   c8x_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               done;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         c8x_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = c8x_pkg::ST_DECODE;
            end
         end
         c8x_pkg::ST_DECODE: begin
            // request latched; dispatch by opcode
            unique case (sts.op)
               c8x_pkg::OP_READ: state_in = c8x_pkg::ST_RDWAIT;
               c8x_pkg::OP_EXEC: state_in = c8x_pkg::ST_FETCH_HI;
               default:          state_in = c8x_pkg::ST_DONE;
            endcase
         end
         c8x_pkg::ST_RDWAIT:   state_in = c8x_pkg::ST_DONE;
         c8x_pkg::ST_FETCH_HI: state_in = c8x_pkg::ST_FETCH_LO;
         c8x_pkg::ST_FETCH_LO: state_in = c8x_pkg::ST_EXEC;
         c8x_pkg::ST_EXEC: begin
            if (sts.is_bcd) begin
               state_in = c8x_pkg::ST_BCD;
            end else if (sts.is_str) begin
               state_in = c8x_pkg::ST_BLK_WR;
            end else if (sts.is_ldr) begin
               state_in = c8x_pkg::ST_BLK_RD;
            end else begin
               state_in = c8x_pkg::ST_DONE;
            end
         end
         c8x_pkg::ST_BCD: begin
            if (sts.cnt_last) state_in = c8x_pkg::ST_DONE;
         end
         c8x_pkg::ST_BLK_WR: begin
            if (sts.cnt_last) state_in = c8x_pkg::ST_DONE;
         end
         c8x_pkg::ST_BLK_RD:   state_in = c8x_pkg::ST_BLK_WAIT;
         c8x_pkg::ST_BLK_WAIT: begin
            state_in = sts.cnt_last ? c8x_pkg::ST_DONE : c8x_pkg::ST_BLK_RD;
         end
         c8x_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = c8x_pkg::ST_IDLE;
         end
         default: state_in = c8x_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         c8x_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
         end
         c8x_pkg::ST_DECODE: begin
            ctl.mem_write = (sts.op == c8x_pkg::OP_WRITE);
            ctl.mem_read  = (sts.op == c8x_pkg::OP_READ);
            ctl.tick      = (sts.op == c8x_pkg::OP_TICK);
            ctl.fetch_hi  = (sts.op == c8x_pkg::OP_EXEC);
         end
         c8x_pkg::ST_RDWAIT:   ctl.rd_capture = 1'b1;
         c8x_pkg::ST_FETCH_HI: ctl.fetch_lo = 1'b1;
         c8x_pkg::ST_FETCH_LO: ctl.decode = 1'b1;
         c8x_pkg::ST_EXEC:     ctl.exec = 1'b1;
         c8x_pkg::ST_BCD:      ctl.bcd_wr = 1'b1;
         c8x_pkg::ST_BLK_WR:   ctl.blk_wr = 1'b1;
         c8x_pkg::ST_BLK_RD:   ctl.blk_rd = 1'b1;
         c8x_pkg::ST_BLK_WAIT: ctl.blk_ld = 1'b1;
         c8x_pkg::ST_DONE: begin
            done         = !rsp_valid_ff || rsp_ready;
            ctl.out_load = done;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (done) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= c8x_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// File: hw/rtl/c8x_datapath.sv
//==============================================================================
// c8x_datapath
// Architectural state, memory, ALU and result register of the CHIP-8 core.
//==============================================================================
`default_nettype none
module c8x_datapath #(
   parameter int MEM_BYTES   = 4096,
   parameter int STACK_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       in_opcode,
   input  wire logic [11:0]      in_address,
   input  wire logic [7:0]       in_write_data,
   input  wire logic [15:0]      in_key_mask,
   input  wire logic [7:0]       in_random_byte,
   input  wire c8x_pkg::ctl_type ctl,
   output c8x_pkg::sts_type      sts,
   output logic [11:0]           o_pc,
   output logic [15:0]           o_index,
   output logic [1:0]            o_disp,
   output logic [7:0]            o_dx,
   output logic [7:0]            o_dy,
   output logic [3:0]            o_rows,
   output logic [7:0]            o_rdata,
   output logic                  o_halt,
   output logic                  o_wait,
   output logic                  o_sound
);
   localparam int SPW = $clog2(STACK_DEPTH);
   localparam int AW  = $clog2(MEM_BYTES);

   // request latch
   logic [1:0]  op_ff;
   logic [11:0] addr_ff;
   logic [7:0]  wdata_ff, rnd_ff;
   logic [15:0] keys_ff;

   // architectural state
   logic [7:0]  regs_ff [16];
   logic [15:0] index_ff;
   logic [11:0] pc_ff;
   logic [11:0] stack_ff [STACK_DEPTH];
   logic [SPW-1:0] sp_ff;
   logic [7:0]  dt_ff, st_ff;

   // per-item working state
   logic [15:0] word_ff;
   logic [7:0]  hi_ff;
   logic [3:0]  cnt_ff;
   logic [7:0]  rdata_ff;
   logic [1:0]  disp_ff;
   logic [7:0]  dx_ff, dy_ff;
   logic [3:0]  rows_ff;
   logic        halt_ff, wait_ff;
   logic [7:0]  bcd_ff [3];

   // memory
   logic           mem_we;
   logic [AW-1:0]  mem_addr;
   logic [7:0]     mem_wdata, mem_rdata;

   c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // decoded fields
   logic [3:0]  wx, wy, wn, hi4;
   logic [7:0]  kk, vx, vy;
   logic [11:0] nnn;
   assign hi4 = word_ff[15:12];
   assign wx  = word_ff[11:8];
   assign wy  = word_ff[7:4];
   assign wn  = word_ff[3:0];
   assign kk  = word_ff[7:0];
   assign nnn = word_ff[11:0];
   assign vx  = regs_ff[wx];
   assign vy  = regs_ff[wy];

   logic [15:0] blk_addr;
   assign blk_addr = index_ff + {12'd0, cnt_ff};

   // memory port select
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = addr_ff[AW-1:0];
      mem_wdata = wdata_ff;
      if (ctl.mem_write) begin
         mem_we = 1'b1;
      end else if (ctl.mem_read) begin
         mem_addr = addr_ff[AW-1:0];
      end else if (ctl.fetch_hi) begin
         mem_addr = pc_ff[AW-1:0];
      end else if (ctl.fetch_lo) begin
         mem_addr = AW'(pc_ff + 12'd1);
      end else if (ctl.bcd_wr) begin
         mem_we    = 1'b1;
         mem_addr  = blk_addr[AW-1:0];
         mem_wdata = bcd_ff[cnt_ff[1:0]];
      end else if (ctl.blk_wr) begin
         mem_we    = 1'b1;
         mem_addr  = blk_addr[AW-1:0];
         mem_wdata = regs_ff[cnt_ff];
      end else if (ctl.blk_rd) begin
         mem_addr = blk_addr[AW-1:0];
      end
   end

   // lowest held key
   logic [3:0] low_key;
   always_comb begin
      low_key = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         if (keys_ff[i]) low_key = 4'(i);
      end
   end

   // BCD digits of VX, small constant-divisor steps
   logic [7:0] hund, rem100, tens, ones;
   always_comb begin
      hund   = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
      rem100 = 8'(vx - 8'(hund * 8'd100));
      tens   = 8'((16'(rem100) * 16'd205) >> 11);
      ones   = 8'(rem100 - 8'(tens * 8'd10));
   end

   logic        key_held;
   logic [8:0]  sum9;
   logic [11:0] pc2;
   assign key_held = keys_ff[vx[3:0]];
   assign sum9     = {1'b0, vx} + {1'b0, vy};
   assign pc2      = 12'(pc_ff + 12'd2);

   // stack pointer steps, wrapping at the stack depth
   logic [SPW-1:0] sp_up, sp_down;
   assign sp_up   = (sp_ff == SPW'(STACK_DEPTH - 1)) ? '0 : SPW'(sp_ff + SPW'(1));
   assign sp_down = (sp_ff == '0) ? SPW'(STACK_DEPTH - 1) : SPW'(sp_ff - SPW'(1));

   // execute
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         op_ff    <= in_opcode;
         addr_ff  <= in_address;
         wdata_ff <= in_write_data;
         keys_ff  <= in_key_mask;
         rnd_ff   <= in_random_byte;
         rdata_ff <= '0;
         disp_ff  <= c8x_pkg::DISP_NONE;
         dx_ff    <= '0;
         dy_ff    <= '0;
         rows_ff  <= '0;
         halt_ff  <= 1'b0;
         wait_ff  <= 1'b0;
         cnt_ff   <= '0;
      end
      if (ctl.rd_capture) rdata_ff <= mem_rdata;
      if (ctl.fetch_lo) hi_ff <= mem_rdata;
      if (ctl.decode) word_ff <= {hi_ff, mem_rdata};
      if (ctl.exec) begin
         bcd_ff[0] <= hund;
         bcd_ff[1] <= tens;
         bcd_ff[2] <= ones;
      end
      if (ctl.bcd_wr || ctl.blk_wr || ctl.blk_ld) cnt_ff <= 4'(cnt_ff + 4'd1);

      if (reset) begin
         for (int i = 0; i < 16; i++) regs_ff[i] <= '0;
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= '0;
         index_ff <= '0;
         pc_ff    <= c8x_pkg::PC_RESET;
         sp_ff    <= '0;
         dt_ff    <= '0;
         st_ff    <= '0;
      end else begin
         if (ctl.tick) begin
            if (dt_ff != 8'd0) dt_ff <= 8'(dt_ff - 8'd1);
            if (st_ff != 8'd0) st_ff <= 8'(st_ff - 8'd1);
         end
         if (ctl.blk_ld) regs_ff[cnt_ff] <= mem_rdata;
         if (ctl.exec) begin
            pc_ff <= pc2;
            if (word_ff == 16'h0000) begin
               halt_ff <= 1'b1;
               pc_ff   <= pc_ff;
            end else begin
               unique case (hi4)
                  4'h0: begin
                     if (word_ff == c8x_pkg::W_CLS) begin
                        disp_ff <= c8x_pkg::DISP_CLEAR;
                     end else if (word_ff == c8x_pkg::W_RET) begin
                        pc_ff <= 12'(stack_ff[sp_ff] + 12'd2);
                        sp_ff <= sp_down;
                     end
                  end
                  4'h1: pc_ff <= nnn;
                  4'h2: begin
                     sp_ff <= sp_up;
                     stack_ff[sp_up] <= pc_ff;
                     pc_ff <= nnn;
                  end
                  4'h3: if (vx == kk) pc_ff <= 12'(pc_ff + 12'd4);
                  4'h4: if (vx != kk) pc_ff <= 12'(pc_ff + 12'd4);
                  4'h5: if (vx == vy) pc_ff <= 12'(pc_ff + 12'd4);
                  4'h6: regs_ff[wx] <= kk;
                  4'h7: regs_ff[wx] <= 8'(vx + kk);
                  4'h8: begin
                     case (wn)
                        4'h0: regs_ff[wx] <= vy;
                        4'h1: regs_ff[wx] <= vx | vy;
                        4'h2: regs_ff[wx] <= vx & vy;
                        4'h3: regs_ff[wx] <= vx ^ vy;
                        4'h4: begin
                           regs_ff[wx] <= sum9[7:0];
                           regs_ff[15] <= {7'd0, sum9[8]};
                        end
                        4'h5: begin
                           regs_ff[wx] <= 8'(vx - vy);
                           regs_ff[15] <= {7'd0, vx >= vy};
                        end
                        4'h6: begin
                           regs_ff[wx] <= vx >> 1;
                           regs_ff[15] <= {7'd0, vx[0]};
                        end
                        4'h7: begin
                           regs_ff[wx] <= 8'(vy - vx);
                           regs_ff[15] <= {7'd0, vy >= vx};
                        end
                        4'hE: begin
                           regs_ff[wx] <= vx << 1;
                           regs_ff[15] <= {7'd0, vx > c8x_pkg::SHL_LIMIT};
                        end
                        default: ;
                     endcase
                  end
                  4'h9: if (vx != vy) pc_ff <= 12'(pc_ff + 12'd4);
                  4'hA: index_ff <= {4'd0, nnn};
                  4'hB: pc_ff <= 12'(nnn + {4'd0, regs_ff[0]});
                  4'hC: regs_ff[wx] <= rnd_ff & kk;
                  4'hD: begin
                     disp_ff <= c8x_pkg::DISP_DRAW;
                     dx_ff   <= vx;
                     dy_ff   <= vy;
                     rows_ff <= wn;
                  end
                  4'hE: begin
                     if ((kk == c8x_pkg::K_SKP && key_held) ||
                         (kk == c8x_pkg::K_SKNP && !key_held)) begin
                        pc_ff <= 12'(pc_ff + 12'd4);
                     end
                  end
                  default: begin
                     case (kk)
                        c8x_pkg::K_GDT: regs_ff[wx] <= dt_ff;
                        c8x_pkg::K_WKEY: begin
                           if (keys_ff == 16'd0) begin
                              wait_ff <= 1'b1;
                              pc_ff   <= pc_ff;
                           end else begin
                              regs_ff[wx] <= {4'd0, low_key};
                           end
                        end
                        c8x_pkg::K_SDT:  dt_ff <= vx;
                        c8x_pkg::K_SST:  st_ff <= vx;
                        c8x_pkg::K_ADDI: index_ff <= 16'(index_ff + {8'd0, vx});
                        c8x_pkg::K_FONT: index_ff <= 16'({8'd0, vx} * 16'd5);
                        default: ;
                     endcase
                  end
               endcase
            end
         end
      end
   end

   // status for the sequencer
   logic is_f;
   assign is_f       = (word_ff != 16'h0000) && (hi4 == 4'hF);
   assign sts.op     = c8x_pkg::req_op_type'(op_ff);
   assign sts.is_bcd = is_f && (kk == c8x_pkg::K_BCD);
   assign sts.is_str = is_f && (kk == c8x_pkg::K_STR);
   assign sts.is_ldr = is_f && (kk == c8x_pkg::K_LDR);
   assign sts.cnt_last = sts.is_bcd ? (cnt_ff == 4'd2) : (cnt_ff == wx);

   // result register
   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         o_pc    <= pc_ff;
         o_index <= index_ff;
         o_disp  <= disp_ff;
         o_dx    <= dx_ff;
         o_dy    <= dy_ff;
         o_rows  <= rows_ff;
         o_rdata <= rdata_ff;
         o_halt  <= halt_ff;
         o_wait  <= wait_ff;
         o_sound <= st_ff != 8'd0;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/chip8_instruction_execute.sv
//==============================================================================
// chip8_instruction_execute
// CHIP-8 core: memory load/inspect, instruction execute and timer tick.
//==============================================================================
// Usage:
//   req carries one transaction: opcode (write, read, execute, tick), address,
//   write_data, key_mask and random_byte. rsp returns one result per
//   transaction: pc, index, display request, read byte and status flags.
//   Transactions are handled one at a time by a sequencer over the single
//   port of the 4 KB memory. Write and tick go straight to the result, read
//   waits for the registered byte, an instruction fetches both bytes and
//   executes, then BCD store writes three digits, block store X+1 bytes and
//   block load reads and latches X+1 bytes. req_ready is high again in the
//   cycle the result appears. Reset sets pc to 512 and clears registers,
//   index, stack and timers; memory content is undefined until written. The
//   result sits in an output register; while rsp_ready is low the core holds
//   it and finishes the next transaction up to its result, then waits.
//==============================================================================
`default_nettype none
module chip8_instruction_execute #(
   parameter int MEM_BYTES   = 4096,
   parameter int STACK_DEPTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   c8x_req_if.sink  req,
   c8x_rsp_if.source rsp
);
   c8x_pkg::ctl_type ctl;
   c8x_pkg::sts_type sts;
   logic [1:0]       disp;

   c8x_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   c8x_datapath #(.MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .in_opcode      (req.opcode),
      .in_address     (req.address),
      .in_write_data  (req.write_data),
      .in_key_mask    (req.key_mask),
      .in_random_byte (req.random_byte),
      .ctl            (ctl),
      .sts            (sts),
      .o_pc           (rsp.program_counter),
      .o_index        (rsp.index_value),
      .o_disp         (disp),
      .o_dx           (rsp.draw_x),
      .o_dy           (rsp.draw_y),
      .o_rows         (rsp.draw_rows),
      .o_rdata        (rsp.read_data),
      .o_halt         (rsp.halted),
      .o_wait         (rsp.waiting_key),
      .o_sound        (rsp.sound_on)
   );

   assign rsp.display_command = disp;
endmodule
`default_nettype wire
